// ===== rtl/reversing_motor_duty_ramp_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for reversing_motor_duty_ramp
// Shared property wrappers, clocked on clk and quiet while rst is high.
// ----------------------------------------------------------------------------
`ifndef REVERSING_MOTOR_DUTY_RAMP_MACROS_SVH
`define REVERSING_MOTOR_DUTY_RAMP_MACROS_SVH

// Same-cycle implication.
`define RMDR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RMDR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rmdr_pkg.sv =====
// ----------------------------------------------------------------------------
// rmdr_pkg
// Types, codes and constants shared by the duty ramp controller and datapath.
// ----------------------------------------------------------------------------
package rmdr_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DUTY_INT_W    = 8;
  localparam int DT_W          = 10;
  localparam int RAMP_W        = 16;
  localparam int OP_W          = 3;
  localparam int DIR_W         = 2;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;
  localparam int PROD_W        = DUTY_INT_W + DT_W;

  localparam logic [RAMP_W-1:0]     RAMP_RESET     = 16'd1000;
  localparam logic [DUTY_INT_W-1:0] MAX_DUTY_RESET = 8'd255;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_TIME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DUTY  = 2'd1;

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 3'd0,
    OP_OPEN  = 3'd1,
    OP_CLOSE = 3'd2,
    OP_STOP  = 3'd3,
    OP_HALT  = 3'd4
  } op_t;

  typedef enum logic [DIR_W-1:0] {
    DIR_STOPPED = 2'd0,
    DIR_OPENING = 2'd1,
    DIR_CLOSING = 2'd2
  } dir_t;

  typedef struct packed {
    logic [OP_W-1:0] operation;
    logic [DT_W-1:0] dt_ms;
  } cmd_t;

  typedef struct packed {
    logic [DUTY_INT_W-1:0] open_drive;
    logic [DUTY_INT_W-1:0] close_drive;
    logic [DIR_W-1:0]      direction;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;   // latch the incoming item
    logic mul;       // form max_duty * dt, load divider
    logic div_step;  // one quotient bit
    logic commit;    // update state, load result register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_is_tick;  // item at the input port is a tick
    logic div_last;    // final quotient bit this cycle
    logic out_free;    // result register can take a new value
  } ctrl_sts_t;

endpackage

// ===== rtl/rmdr_ctrl.sv =====
// ----------------------------------------------------------------------------
// rmdr_ctrl
// Sequencer: accept, multiply, serial divide, commit.
// ----------------------------------------------------------------------------
module rmdr_ctrl
  import rmdr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_stall,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t ctl
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_COMMIT
  } state_t;

  state_t state;
  logic   busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            busy  <= 1'b1;
            state <= sts.in_is_tick ? S_MUL : S_COMMIT;
          end
        end
        S_MUL: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (sts.div_last) begin
            state <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          if (sts.out_free) begin
            busy  <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: begin
          busy  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign cmd_stall = busy;

  always_comb begin
    ctl.capture  = (state == S_IDLE) && cmd_valid;
    ctl.mul      = (state == S_MUL);
    ctl.div_step = (state == S_DIV);
    ctl.commit   = (state == S_COMMIT) && sts.out_free;
  end

endmodule

// ===== rtl/rmdr_dp.sv =====
// ----------------------------------------------------------------------------
// rmdr_dp
// Config registers, motor state, step multiplier, serial divider, result reg.
// ----------------------------------------------------------------------------
module rmdr_dp
  import rmdr_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  ctrl_cmd_t             ctl,
  output ctrl_sts_t             sts,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result
);

  localparam int DUTY_W = DUTY_INT_W + FRAC_BITS;
  localparam int NUM_W  = PROD_W + FRAC_BITS;
  localparam int CNT_W  = $clog2(NUM_W);
  localparam int SUM_W  = NUM_W + 1;

  logic [RAMP_W-1:0]     ramp_time_ms;
  logic [DUTY_INT_W-1:0] max_duty;
  dir_t                  req_dir;
  dir_t                  cur_dir;
  logic [DUTY_W-1:0]     duty;

  logic [OP_W-1:0]       op_q;
  logic [DT_W-1:0]       dt_q;
  logic [NUM_W-1:0]      num;   // numerator in, quotient out
  logic [RAMP_W-1:0]     rem;
  logic [CNT_W-1:0]      cnt;

  // divider step
  logic [RAMP_W:0]       rem_sh;
  logic                  rem_ge;
  logic [PROD_W-1:0]     prod;

  // commit logic
  dir_t                  req_next;
  dir_t                  cur_next;
  logic [DUTY_W-1:0]     duty_next;
  logic [SUM_W-1:0]      sum;
  logic [SUM_W-1:0]      ceil_ext;
  logic [NUM_W-1:0]      duty_ext;
  logic [DUTY_INT_W-1:0] whole;

  assign sts.in_is_tick = (cmd.operation == OP_TICK);
  assign sts.div_last   = (cnt == CNT_W'(NUM_W - 1));
  assign sts.out_free   = !result_valid || !result_stall;

  // config writes; a zero ramp time is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_time_ms <= RAMP_RESET;
      max_duty     <= MAX_DUTY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RAMP_TIME: begin
          if (cfg_data != '0) begin
            ramp_time_ms <= cfg_data[RAMP_W-1:0];
          end
        end
        CFG_MAX_DUTY: begin
          max_duty <= cfg_data[DUTY_INT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign prod   = PROD_W'(max_duty) * PROD_W'(dt_q);
  assign rem_sh = {rem, num[NUM_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, ramp_time_ms});

  // item capture, multiply, restoring divide (one bit per cycle)
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      op_q <= cmd.operation;
      dt_q <= cmd.dt_ms;
    end
    if (ctl.mul) begin
      num <= {prod, {FRAC_BITS{1'b0}}};
      rem <= '0;
      cnt <= '0;
    end else if (ctl.div_step) begin
      num <= {num[NUM_W-2:0], rem_ge};
      rem <= rem_ge ? RAMP_W'(rem_sh - {1'b0, ramp_time_ms}) : rem_sh[RAMP_W-1:0];
      cnt <= cnt + CNT_W'(1);
    end
  end

  assign sum      = {1'b0, num} + SUM_W'(duty);
  assign ceil_ext = SUM_W'({max_duty, {FRAC_BITS{1'b0}}});
  assign duty_ext = NUM_W'(duty);

  always_comb begin
    req_next  = req_dir;
    cur_next  = cur_dir;
    duty_next = duty;
    case (op_q)
      OP_TICK: begin
        if (req_dir == cur_dir && req_dir != DIR_STOPPED) begin
          duty_next = (sum > ceil_ext) ? ceil_ext[DUTY_W-1:0] : sum[DUTY_W-1:0];
        end else if (duty_ext <= num) begin
          duty_next = '0;
          cur_next  = req_dir;
        end else begin
          duty_next = duty - num[DUTY_W-1:0];
        end
      end
      OP_OPEN:  req_next = DIR_OPENING;
      OP_CLOSE: req_next = DIR_CLOSING;
      OP_STOP:  req_next = DIR_STOPPED;
      OP_HALT: begin
        req_next  = DIR_STOPPED;
        cur_next  = DIR_STOPPED;
        duty_next = '0;
      end
      default: begin
      end
    endcase
  end

  assign whole = duty_next[DUTY_W-1 -: DUTY_INT_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      req_dir      <= DIR_STOPPED;
      cur_dir      <= DIR_STOPPED;
      duty         <= '0;
      result_valid <= 1'b0;
    end else begin
      if (ctl.commit) begin
        req_dir      <= req_next;
        cur_dir      <= cur_next;
        duty         <= duty_next;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      result.open_drive  <= (cur_next == DIR_OPENING) ? whole : '0;
      result.close_drive <= (cur_next == DIR_CLOSING) ? whole : '0;
      result.direction   <= cur_next;
    end
  end

endmodule

// ===== rtl/reversing_motor_duty_ramp.sv =====
// ----------------------------------------------------------------------------
// reversing_motor_duty_ramp
// Soft-start PWM duty ramp for a reversible motor with two drive legs.
// ----------------------------------------------------------------------------
// Usage:
//  - cmd channel (cmd_valid / cmd_stall / cmd): one item per transfer, either
//    a tick with elapsed ms or an open / close / stop / halt command.
//  - result channel (result_valid / result_stall / result): exactly one
//    transfer per item: duty on the active leg, zero on the other, direction.
//  - cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): reg 0 ramp
//    time in ms (zero write ignored), reg 1 max duty. cfg_ready is always
//    high; write only while no item is in flight.
//  - Tick: the multiply step forms max_duty * dt, then a restoring divider
//    by the ramp time produces one quotient bit per cycle over 18 + FRAC_BITS
//    bits. Result is loaded in the commit step; the next item is taken once
//    the sequencer is back in idle. Commands skip the multiply and divide
//    steps and go straight to commit.
//  - A waiting result does not block intake: a new item is taken and worked
//    on; it only holds in its commit step while result_stall keeps the
//    previous result in the output register.
//  - Sync reset: stopped, zero duty, ramp 1000 ms, max duty 255, no result.
// ----------------------------------------------------------------------------
`include "reversing_motor_duty_ramp_macros.svh"

module reversing_motor_duty_ramp
  import rmdr_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // item input
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  cmd_t                  cmd,
  // result output
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctrl_cmd_t ctl;
  ctrl_sts_t sts;
  logic      both_legs;

  // config registers sit in the datapath and take a write on any cycle
  assign cfg_ready = 1'b1;

  rmdr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  rmdr_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .ctl          (ctl),
    .sts          (sts),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  assign both_legs = (result.open_drive != '0) && (result.close_drive != '0);

  // one item in flight: intake closes right after a transfer
  `RMDR_ASSERT_NEXT(a_busy_after_take, cmd_valid && !cmd_stall, cmd_stall, "intake not closed")

  // a new result only comes out of a busy sequencer
  `RMDR_ASSERT_NOW(a_result_from_busy, $rose(result_valid), $past(cmd_stall), "stray result")

  // never drive both legs
  `RMDR_ASSERT_NOW(a_one_leg, result_valid, !both_legs, "both legs driven")

endmodule

// ===== sim/reversing_motor_duty_ramp_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// reversing_motor_duty_ramp_tb
// Self-checking bench for the reversible motor duty ramp. A scoreboard keeps
// its own copy of direction, duty and registers, predicts the drive outputs
// for every transfer on the command channel and compares each result
// transfer in order. A directed walk comes first, then random command/tick
// bursts under a series of register settings and back-pressure mixes.
// ----------------------------------------------------------------------------
module reversing_motor_duty_ramp_tb;
  import rmdr_pkg::*;

  localparam int FRAC    = FRAC_BITS_DEF;
  localparam int LEVEL_W = DUTY_INT_W + FRAC;

  // spare codes the block must treat as no-ops
  localparam logic [OP_W-1:0]      OP_SPARE_LO  = 3'd5;
  localparam logic [OP_W-1:0]      OP_SPARE_MID = 3'd6;
  localparam logic [OP_W-1:0]      OP_SPARE_HI  = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3  = 2'd3;

  localparam int SETTLE_CYCLES = 64;
  localparam int STALL_LIMIT   = 4000;
  localparam int PHASE_ITEMS   = 170;
  localparam int NUM_PHASES    = 10;

  // --------------------------------------------------------------------------
  // Scoreboard: drive predictor plus queue of drive results still due
  // --------------------------------------------------------------------------
  class duty_ramp_scoreboard;
    logic [RAMP_W-1:0]     ramp_ms;
    logic [DUTY_INT_W-1:0] duty_cap;
    dir_t                  want_dir;
    dir_t                  live_dir;
    logic [LEVEL_W-1:0]    level;
    result_t               drive_due_q[$];
    int                    errors;

    function new();
      ramp_ms  = RAMP_RESET;
      duty_cap = MAX_DUTY_RESET;
      want_dir = DIR_STOPPED;
      live_dir = DIR_STOPPED;
      level    = '0;
      errors   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_RAMP_TIME) begin
        if (data != '0) ramp_ms = data;   // zero would divide by zero: dropped
      end else if (idx == CFG_MAX_DUTY) begin
        duty_cap = data[DUTY_INT_W-1:0];
      end
    endfunction

    // Advance the motor state by one accepted item, queue the drive it shows.
    function void advance_drive(cmd_t item);
      bit [63:0] ceil_lvl;
      bit [63:0] step;
      bit [63:0] sum;
      logic [DUTY_INT_W-1:0] whole;
      result_t drv;
      case (item.operation)
        OP_TICK: begin
          ceil_lvl = 64'(duty_cap) << FRAC;
          step = ((64'(duty_cap) * 64'(item.dt_ms)) << FRAC) / 64'(ramp_ms);
          if (want_dir == live_dir && want_dir != DIR_STOPPED) begin
            sum   = 64'(level) + step;
            level = (sum > ceil_lvl) ? LEVEL_W'(ceil_lvl) : LEVEL_W'(sum);
          end else if (64'(level) <= step) begin
            // came to rest: only now may the direction flip
            level    = '0;
            live_dir = want_dir;
          end else begin
            level = level - LEVEL_W'(step);
          end
        end
        OP_OPEN:  want_dir = DIR_OPENING;
        OP_CLOSE: want_dir = DIR_CLOSING;
        OP_STOP:  want_dir = DIR_STOPPED;
        OP_HALT: begin
          want_dir = DIR_STOPPED;
          live_dir = DIR_STOPPED;
          level    = '0;
        end
        default: ;
      endcase
      whole = level[LEVEL_W-1:FRAC];
      drv.open_drive  = (live_dir == DIR_OPENING) ? whole : '0;
      drv.close_drive = (live_dir == DIR_CLOSING) ? whole : '0;
      drv.direction   = live_dir;
      drive_due_q.push_back(drv);
    endfunction

    function void check_drive(result_t got);
      result_t want;
      if (drive_due_q.size() == 0) begin
        $display("%0t: unexpected result transfer, actual %h", $time, got);
        errors++;
        return;
      end
      want = drive_due_q.pop_front();
      if (got.open_drive !== want.open_drive) begin
        $display("%0t: open_drive expected %0d actual %0d",
                 $time, want.open_drive, got.open_drive);
        errors++;
      end
      if (got.close_drive !== want.close_drive) begin
        $display("%0t: close_drive expected %0d actual %0d",
                 $time, want.close_drive, got.close_drive);
        errors++;
      end
      if (got.direction !== want.direction) begin
        $display("%0t: direction expected %0d actual %0d",
                 $time, want.direction, got.direction);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cmd_valid = 1'b0;
  logic                  cmd_stall;
  cmd_t                  cmd = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  result_t               result;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  duty_ramp_scoreboard sb = new();

  // percent of cycles each side holds off
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles  = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  reversing_motor_duty_ramp dut (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_stall    (cmd_stall),
    .cmd          (cmd),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Result side: check every transfer, then pick next cycle's stall.
  // Values read right after the edge are the pre-edge ones (all NBA driven).
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_drive(result);
    result_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog: any transfer on any channel counts as progress.
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Command side
  // --------------------------------------------------------------------------
  // One command transfer, with random hold-off before valid goes up.
  // Valid is left high on return so back-to-back items keep it asserted.
  task automatic send_item(input cmd_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= item;
    do @(posedge clk); while (cmd_stall);
    sb.advance_drive(item);
  endtask

  // Drop valid, wait for every due result, then let the datapath settle.
  task automatic drain();
    cmd_valid <= 1'b0;
    while (sb.drive_due_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Idle-only register update; also pokes the zero ramp and spare indexes,
  // which must leave the settings alone.
  task automatic apply_setting(input logic [RAMP_W-1:0] ramp,
                               input logic [DUTY_INT_W-1:0] cap);
    logic [CFG_IDX_W-1:0]  idx_list [5];
    logic [CFG_DATA_W-1:0] data_list [5];
    drain();
    idx_list  = '{CFG_RAMP_TIME, CFG_MAX_DUTY, CFG_RAMP_TIME, CFG_SPARE_2, CFG_SPARE_3};
    data_list = '{ramp, {8'($urandom), cap}, 16'd0, 16'($urandom), 16'($urandom)};
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx_list[i];
      cfg_data  <= data_list[i];
      do @(posedge clk); while (!cfg_ready);
      sb.write_reg(idx_list[i], data_list[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // Random traffic: usually a command (mostly direction requests) followed
  // by a burst of ticks, so ramps, clamps and reversals all get exercised.
  task automatic run_traffic(input int n_items);
    int   sent;
    int   pick;
    int   burst;
    cmd_t item;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      item.dt_ms = 10'($urandom);
      if      (pick < 35) item.operation = OP_OPEN;
      else if (pick < 65) item.operation = OP_CLOSE;
      else if (pick < 80) item.operation = OP_STOP;
      else if (pick < 87) item.operation = OP_HALT;
      else                item.operation = 3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
      if (pick < 92) begin
        send_item(item);
        sent++;
      end
      burst = $urandom_range(8, 1);
      repeat (burst) begin
        item.operation = OP_TICK;
        pick = $urandom_range(99);
        if      (pick < 10) item.dt_ms = pick[0] ? '1 : '0;   // extremes
        else if (pick < 55) item.dt_ms = 10'($urandom_range(31));
        else                item.dt_ms = 10'($urandom);
        send_item(item);
        sent++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    cmd_t                  walk_q [$];
    logic [RAMP_W-1:0]     ramp_set [NUM_PHASES];
    logic [DUTY_INT_W-1:0] cap_set  [NUM_PHASES];

    // phase 0 runs on reset values; later ones cover both ends of each range
    ramp_set = '{16'd1000, 16'd1000, 16'd1, 16'd65535, 16'd65535, 16'd1,
                 16'd250, 16'($urandom_range(3000, 1)), 16'($urandom_range(65535, 1)),
                 16'd1000};
    cap_set  = '{8'd255, 8'd100, 8'd255, 8'd255, 8'd0, 8'd0,
                 8'd200, 8'($urandom), 8'($urandom), 8'd255};

    // Directed walk under reset settings (1000 ms, full duty).
    walk_q = '{
      '{operation: OP_TICK,  dt_ms: 10'd1023},   // tick at rest: nothing moves
      '{operation: OP_SPARE_LO, dt_ms: 10'd0},   // spare opcodes
      '{operation: OP_SPARE_MID, dt_ms: 10'h155},
      '{operation: OP_SPARE_HI, dt_ms: 10'h3FF},
      '{operation: OP_OPEN,  dt_ms: 10'h2AA},
      '{operation: OP_TICK,  dt_ms: 10'd0},      // zero step still starts from rest
      '{operation: OP_TICK,  dt_ms: 10'd1023},   // overshoot clamps at max duty
      '{operation: OP_STOP,  dt_ms: 10'h3FF},
      '{operation: OP_TICK,  dt_ms: 10'd1},      // stop request ramps down
      '{operation: OP_CLOSE, dt_ms: 10'd0},
      '{operation: OP_TICK,  dt_ms: 10'd1023},   // reaches rest, flips to closing
      '{operation: OP_TICK,  dt_ms: 10'd0},
      '{operation: OP_TICK,  dt_ms: 10'd600},
      '{operation: OP_OPEN,  dt_ms: 10'd0},      // reversal goes through rest
      '{operation: OP_TICK,  dt_ms: 10'd200},
      '{operation: OP_TICK,  dt_ms: 10'd1023},
      '{operation: OP_HALT,  dt_ms: 10'h3FF},    // halt while running
      '{operation: OP_CLOSE, dt_ms: 10'd0},
      '{operation: OP_TICK,  dt_ms: 10'd1023},
      '{operation: OP_TICK,  dt_ms: 10'd1023},
      '{operation: OP_HALT,  dt_ms: 10'd0},
      '{operation: OP_OPEN,  dt_ms: 10'd0},
      '{operation: OP_TICK,  dt_ms: 10'd0},
      '{operation: OP_TICK,  dt_ms: 10'd1023}    // left at full duty: next phase
    };                                           // lowers the cap under it

    send_idle_pct = 16;
    recv_idle_pct = 78;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (walk_q[i]) send_item(walk_q[i]);

    for (int p = 1; p < NUM_PHASES; p++) begin
      apply_setting(ramp_set[p], cap_set[p]);
      // back-pressure mix: sender light / receiver heavy, swapped, then none
      if (p <= 3) begin
        send_idle_pct = 16;
        recv_idle_pct = 78;
      end else if (p <= 6) begin
        send_idle_pct = 78;
        recv_idle_pct = 16;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      run_traffic(PHASE_ITEMS);
    end

    drain();
    if (sb.errors == 0 && sb.drive_due_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/rmdr_pkg.sv
rtl/rmdr_ctrl.sv
rtl/rmdr_dp.sv
rtl/reversing_motor_duty_ramp.sv
sim/reversing_motor_duty_ramp_tb.sv
